FILE: src/unf_pkg.sv
// ============================================================================
// unf_pkg
// Shared types and constants for the PNG scanline unfilter: stream payloads,
// filter codes, configuration register indexes and the front-to-back command.
// ============================================================================
package unf_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES       = 1'b1;

    localparam int BPP_CFG_W = 3;
    localparam int ROW_CFG_W = 13;
    localparam int CFG_DATA_W = 13;

    // Command field widths, sized for the largest supported line store
    localparam int CMD_COL_W  = 16;
    localparam int CMD_SLOT_W = 3;

    // Entries in the front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
    } out_item_t;

    // One data byte, classified by the front
    typedef struct packed {
        logic [7:0]            raw;
        logic [CMD_COL_W-1:0]  col;
        logic [CMD_SLOT_W-1:0] slot;
        logic                  use_left;
        filter_t               filter;
        logic                  first_row;
        logic                  last;
    } cmd_t;

endpackage

FILE: src/unf_stream_if.sv
// ============================================================================
// unf_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ============================================================================
interface unf_stream_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/png_scanline_unfilter.sv
// ============================================================================
// png_scanline_unfilter
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth) over an
// inflated byte stream, one byte per cycle while the output is not stalled.
//
//   channel     dir  payload                       notes
//   filtered    in   data_byte[7:0], image_start   filter byte then row data
//   unfiltered  out  pixel_byte[7:0], row_end      one request per data byte
//   cfg_*       in   cfg_index, cfg_data           write only, while idle
//
// Sustained rate is one byte per cycle without output stalls; the line store
// has one read and one write port, and the left neighbor loop closes through a
// register. A data byte passes the queue, the read stage and the output register.
// Filter bytes produce no output. Reset leaves the line store as zero through
// a fill count, so no clearing pass is needed; the block is ready at once.
// Output stalls back up through a two-entry queue to filtered.ready.
// ============================================================================
module png_scanline_unfilter
    import unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    unf_stream_if.sink             filtered,
    unf_stream_if.source           unfiltered,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [BPP_CFG_W-1:0] bpp_reg, bpp_next;
    logic [ROW_CFG_W-1:0] row_bytes_reg, row_bytes_next;

    logic q_full;
    logic q_push;
    cmd_t q_item;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    // Decode configuration writes
    always_comb
    begin
        bpp_next       = bpp_reg;
        row_bytes_next = row_bytes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BYTES_PER_PIXEL: bpp_next       = cfg_data[BPP_CFG_W-1:0];
                CFG_ROW_BYTES:       row_bytes_next = cfg_data[ROW_CFG_W-1:0];
                default:             bpp_next       = bpp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_CFG_W'(1);
            row_bytes_reg <= ROW_CFG_W'(1);
        end
        else
        begin
            bpp_reg       <= bpp_next;
            row_bytes_reg <= row_bytes_next;
        end
    end

    unf_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .filtered        (filtered),
        .bytes_per_pixel (bpp_reg),
        .row_bytes       (row_bytes_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (q_item)
    );

    unf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    unf_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .unfiltered (unfiltered)
    );

endmodule

FILE: src/unf_ram.sv
// ============================================================================
// unf_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/unf_queue.sv
// ============================================================================
// unf_queue
// Short command queue between the front and the back of the unfilter.
// ============================================================================
module unf_queue
    import unf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_item,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/unf_front.sv
// ============================================================================
// unf_front
// Accepts stream bytes, tracks row position and filter type, drops filter
// bytes and turns each data byte into a command for the back.
// ============================================================================
module unf_front
    import unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    unf_stream_if.sink           filtered,
    input  logic [BPP_CFG_W-1:0] bytes_per_pixel,
    input  logic [ROW_CFG_W-1:0] row_bytes,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_item
);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int FILL_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int CMP_W  = ((ROW_CFG_W > FILL_W) ? ROW_CFG_W : FILL_W) + 1;
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BPP_W  = 4;

    logic             expect_filter_reg, expect_filter_next;
    logic             first_row_reg, first_row_next;
    filter_t          filter_reg, filter_next;
    logic [COL_W-1:0] col_reg, col_next;
    // Column residue modulo (i+1), one counter per supported pixel size
    logic [2:0]       mod_reg [MAX_PIXEL_BYTES];
    logic [2:0]       mod_next [MAX_PIXEL_BYTES];

    logic             accept;
    logic             at_filter;
    logic [7:0]       raw;
    logic [BPP_W-1:0] bpp_eff;
    logic [CMP_W-1:0] row_eff;
    logic [BPP_W-1:0] bpp_idx;
    logic             last;
    logic             use_left;
    logic [SLOT_W-1:0] slot;

    assign filtered.ready = !q_full;
    assign accept    = filtered.valid && filtered.ready;
    assign raw       = filtered.payload.data_byte;
    assign at_filter = expect_filter_reg || filtered.payload.image_start;

    // Clamp the configuration to the supported range
    always_comb
    begin
        if (bytes_per_pixel == '0)
        begin
            bpp_eff = BPP_W'(1);
        end
        else if (BPP_W'(bytes_per_pixel) > BPP_W'(MAX_PIXEL_BYTES))
        begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end
        else
        begin
            bpp_eff = BPP_W'(bytes_per_pixel);
        end

        if (row_bytes == '0)
        begin
            row_eff = CMP_W'(1);
        end
        else if (CMP_W'(row_bytes) > CMP_W'(MAX_ROW_BYTES))
        begin
            row_eff = CMP_W'(MAX_ROW_BYTES);
        end
        else
        begin
            row_eff = CMP_W'(row_bytes);
        end
    end

    // Classify the current data byte
    always_comb
    begin
        bpp_idx  = bpp_eff - 1'b1;
        slot     = SLOT_W'(mod_reg[bpp_idx[SLOT_W-1:0]]);
        use_left = (CMP_W'(col_reg) >= CMP_W'(bpp_eff));
        last     = (CMP_W'(col_reg) + 1'b1) >= row_eff;
    end

    always_comb
    begin
        q_push              = accept && !at_filter;
        q_item.raw          = raw;
        q_item.col          = CMD_COL_W'(col_reg);
        q_item.slot         = CMD_SLOT_W'(slot);
        q_item.use_left     = use_left;
        q_item.filter       = filter_reg;
        q_item.first_row    = first_row_reg;
        q_item.last         = last;
    end

    // Advance row position, latch filter type on the filter byte
    always_comb
    begin
        expect_filter_next = expect_filter_reg;
        first_row_next     = first_row_reg;
        filter_next        = filter_reg;
        col_next           = col_reg;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            mod_next[i] = mod_reg[i];
        end

        if (accept)
        begin
            if (at_filter)
            begin
                expect_filter_next = 1'b0;
                if (filtered.payload.image_start)
                begin
                    first_row_next = 1'b1;
                end
                if (raw > 8'd4)
                begin
                    filter_next = FILT_NONE;
                end
                else
                begin
                    filter_next = filter_t'(raw[2:0]);
                end
                col_next = '0;
                for (int i = 0; i < MAX_PIXEL_BYTES; i++)
                begin
                    mod_next[i] = '0;
                end
            end
            else if (last)
            begin
                expect_filter_next = 1'b1;
                first_row_next     = 1'b0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                for (int i = 0; i < MAX_PIXEL_BYTES; i++)
                begin
                    mod_next[i] = (mod_reg[i] == 3'(i)) ? 3'd0 : mod_reg[i] + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_filter_reg <= 1'b1;
            first_row_reg     <= 1'b1;
            filter_reg        <= FILT_NONE;
            col_reg           <= '0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                mod_reg[i] <= '0;
            end
        end
        else
        begin
            expect_filter_reg <= expect_filter_next;
            first_row_reg     <= first_row_next;
            filter_reg        <= filter_next;
            col_reg           <= col_next;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                mod_reg[i] <= mod_next[i];
            end
        end
    end

endmodule

FILE: src/unf_back.sv
// ============================================================================
// unf_back
// Reads the byte above from the line store, applies the row's filter with
// the left and upper-left history, writes the result back and presents it.
// ============================================================================
module unf_back
    import unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_head,
    output logic        q_pop,
    unf_stream_if.source unfiltered
);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int FILL_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    function automatic logic [8:0] abs_diff(input logic [8:0] a, input logic [8:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Read stage
    logic             s1_valid_reg, s1_valid_next;
    cmd_t             s1_cmd_reg;
    logic             s1_hit_reg;
    logic             s1_bypass_reg;
    logic [7:0]       s1_bypass_data_reg;

    // Row history and line store fill extent
    logic [7:0]       left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]       diag_hist_reg [MAX_PIXEL_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg;

    logic             done;
    logic [COL_W-1:0] s1_col;
    logic [COL_W-1:0] q_col;
    logic [SLOT_W-1:0] s1_slot;
    logic [7:0]       ram_rdata;
    logic [7:0]       up, left, diag, pred, val;
    logic [8:0]       sum_ab, pa, pb, pc;

    assign s1_col  = s1_cmd_reg.col[COL_W-1:0];
    assign s1_slot = s1_cmd_reg.slot[SLOT_W-1:0];
    assign q_col   = q_head.col[COL_W-1:0];

    // Finish the read stage when the output register can take the result
    assign done  = s1_valid_reg && (!out_valid_reg || unfiltered.ready);
    assign q_pop = q_valid && (!s1_valid_reg || done);

    unf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (done),
        .waddr (s1_col),
        .wdata (val),
        .re    (q_pop),
        .raddr (q_col),
        .rdata (ram_rdata)
    );

    // Gather neighbors: above, left, upper-left
    always_comb
    begin
        if (s1_cmd_reg.first_row)
        begin
            up = '0;
        end
        else if (s1_bypass_reg)
        begin
            up = s1_bypass_data_reg;
        end
        else if (s1_hit_reg)
        begin
            up = ram_rdata;
        end
        else
        begin
            up = '0;
        end

        if (s1_cmd_reg.use_left)
        begin
            left = left_hist_reg[s1_slot];
            diag = s1_cmd_reg.first_row ? 8'd0 : diag_hist_reg[s1_slot];
        end
        else
        begin
            left = '0;
            diag = '0;
        end
    end

    // Apply the filter predictor
    always_comb
    begin
        sum_ab = {1'b0, left} + {1'b0, up};
        pa     = abs_diff({1'b0, up}, {1'b0, diag});
        pb     = abs_diff({1'b0, left}, {1'b0, diag});
        pc     = abs_diff(sum_ab, {diag, 1'b0});
        case (s1_cmd_reg.filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                begin
                    pred = left;
                end
                else if (pb <= pc)
                begin
                    pred = up;
                end
                else
                begin
                    pred = diag;
                end
            end
            default:    pred = '0;
        endcase
        val = s1_cmd_reg.raw + pred;
    end

    // Stage control and fill extent
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (done)
        begin
            s1_valid_next = 1'b0;
        end

        fill_next = fill_reg;
        if (done && (FILL_W'(s1_col) >= fill_reg))
        begin
            fill_next = FILL_W'(s1_col) + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (unfiltered.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i] <= '0;
                diag_hist_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (done)
            begin
                left_hist_reg[s1_slot] <= val;
                diag_hist_reg[s1_slot] <= up;
            end
        end
    end

    // Load the read stage; forward a same-column write from the finishing byte
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_cmd_reg         <= q_head;
            s1_hit_reg         <= (FILL_W'(q_col) < fill_reg);
            s1_bypass_reg      <= done && (s1_col == q_col);
            s1_bypass_data_reg <= val;
        end
        if (done)
        begin
            out_item_reg.pixel_byte <= val;
            out_item_reg.row_end    <= s1_cmd_reg.last;
        end
    end

    assign unfiltered.valid   = out_valid_reg;
    assign unfiltered.payload = out_item_reg;

endmodule

FILE: sim/tb_png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter
// Self-checking bench for the PNG scanline unfilter. A byte-level predictor
// tracks the line store, the left and upper-left history and the row counter,
// and predicts every reconstructed byte with its end-of-row flag. Directed
// rows cover each filter, unknown filter codes, register extremes, a row cut
// short by a register write and an image start in the middle of a row; random
// phases then vary both registers under bursty requests and receiver stalls,
// and a final phase runs rows at the largest pixel size.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
    import unf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LIMIT      = 4096;
    localparam int PIX_LIMIT      = 4;
    localparam int RANDOM_ITEMS   = 300;
    localparam int FINAL_ROW      = 48;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_BEAT} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic     in_valid = 1'b0;
    in_item_t in_item  = '0;
    logic     rx_ready = 1'b0;
    logic     in_taken = 1'b0;

    unf_stream_if #(.T(in_item_t))  filtered_ch ();
    unf_stream_if #(.T(out_item_t)) unfiltered_ch ();

    assign filtered_ch.valid   = in_valid;
    assign filtered_ch.payload = in_item;
    assign unfiltered_ch.ready = rx_ready;

    png_scanline_unfilter #(
        .MAX_ROW_BYTES   (ROW_LIMIT),
        .MAX_PIXEL_BYTES (PIX_LIMIT)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .filtered   (filtered_ch),
        .unfiltered (unfiltered_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor state: register copies and the decoder's own history
    logic [2:0]  bpp_reg = 3'd1;
    logic [12:0] row_reg = 13'd1;
    logic [7:0]  line_store [ROW_LIMIT];
    logic [7:0]  left_hist [PIX_LIMIT];
    logic [7:0]  diag_hist [PIX_LIMIT];
    int unsigned col_count = 0;
    filter_t     cur_filter = FILT_NONE;
    bit          first_row = 1'b1;

    in_item_t    stream_q [$];
    out_item_t   expected_pixels [$];
    int unsigned queued_items = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    // Sender burst shaping and receiver stall pattern
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int unsigned mode_left = 0;
    int unsigned rx_beat = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    initial
    begin
        foreach (line_store[i]) line_store[i] = 8'd0;
        foreach (left_hist[i])
        begin
            left_hist[i] = 8'd0;
            diag_hist[i] = 8'd0;
        end
    end

    function automatic int unsigned row_len();
        if (row_reg == 13'd0)
            return 1;
        if (int'(row_reg) > ROW_LIMIT)
            return ROW_LIMIT;
        return int'(row_reg);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int pa, pb, pc;
        // p = a + b - c; distances to a, b and c reduce to these
        pa = int'(b) - int'(c);
        pb = int'(a) - int'(c);
        pc = int'(a) + int'(b) - 2 * int'(c);
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    // Advance the decoder by one stream byte; return 1 with the rebuilt byte
    function automatic bit unfilter_byte(input in_item_t item, output out_item_t res);
        int unsigned bpp, rlen, col, slot;
        logic [7:0]  left, up, diag, pred, val;
        int          avg_sum;
        bit          last;
        res = '0;
        if (item.image_start)
        begin
            first_row = 1'b1;
            col_count = 0;
        end
        // Filter byte: latch the filter, no output
        if (col_count == 0)
        begin
            cur_filter = (item.data_byte > 8'd4) ? FILT_NONE : filter_t'(item.data_byte[2:0]);
            col_count = 1;
            return 1'b0;
        end
        bpp = (bpp_reg == 3'd0) ? 1
              : ((int'(bpp_reg) > PIX_LIMIT) ? PIX_LIMIT : int'(bpp_reg));
        rlen = row_len();
        col = col_count - 1;
        if (col >= ROW_LIMIT)
            col = ROW_LIMIT - 1;
        slot = col % bpp;
        up = first_row ? 8'd0 : line_store[col];
        if (col >= bpp)
        begin
            left = left_hist[slot];
            diag = first_row ? 8'd0 : diag_hist[slot];
        end
        else
        begin
            left = 8'd0;
            diag = 8'd0;
        end
        case (cur_filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:
            begin
                avg_sum = int'(left) + int'(up);
                pred = 8'(avg_sum / 2);
            end
            FILT_PAETH: pred = paeth_pick(left, up, diag);
            default:    pred = 8'd0;
        endcase
        val = item.data_byte + pred;
        diag_hist[slot] = up;
        left_hist[slot] = val;
        line_store[col] = val;
        last = (col + 1) >= rlen;
        if (last)
        begin
            col_count = 0;
            first_row = 1'b0;
        end
        else
            col_count = col + 2;
        res.pixel_byte = val;
        res.row_end = last;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_filter();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(5, 255));
        return 8'($urandom_range(0, 4));
    endfunction

    task automatic queue_byte(input logic [7:0] value, input logic start);
        in_item_t item;
        item.data_byte = value;
        item.image_start = start;
        stream_q.push_back(item);
        queued_items++;
    endtask

    // Queue a filter byte and len data bytes, optionally with stray image starts
    task automatic queue_row(input bit start, input logic [7:0] filt, input int unsigned len,
                             input bit noisy);
        queue_byte(filt, start);
        for (int i = 0; i < len; i++)
            queue_byte(rand_byte(), noisy && ($urandom_range(0, 49) == 0));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_BYTES_PER_PIXEL)
            bpp_reg = value[2:0];
        else
            row_reg = value[12:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every byte is back, then let the
    // pipeline drain for the drain period
    task automatic wait_idle();
        do
            @(posedge clk);
        while (stream_q.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Driver: hold a request until taken, then send the next one or idle
    always @(negedge clk)
    begin
        if (rst_n && (in_taken || !in_valid))
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (stream_q.size() != 0)
            begin
                in_valid <= 1'b1;
                in_item  <= stream_q.pop_front();
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left <= $urandom_range(64, 256);
                        gap_left   <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(0, 6);
                    end
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: one long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rx_ready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            rx_ready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_FREE: rx_ready <= 1'b1;
                RX_COIN: rx_ready <= 1'($urandom_range(0, 1));
                RX_SLOW: rx_ready <= ($urandom_range(0, 3) == 0);
                default: rx_ready <= (rx_beat % 5) < 3;
            endcase
            rx_beat <= rx_beat + 1;
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
        end
    end

    // Monitor: predict on each taken request, check each delivered byte
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        out_item_t got;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= filtered_ch.valid && filtered_ch.ready;
            if (filtered_ch.valid && filtered_ch.ready)
            begin
                if (unfilter_byte(filtered_ch.payload, want))
                    expected_pixels.push_back(want);
            end
            if (unfiltered_ch.valid && unfiltered_ch.ready)
            begin
                got = unfiltered_ch.payload;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected byte: pixel_byte=%02h row_end=%0b",
                           got.pixel_byte, got.row_end);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_byte !== want.pixel_byte)
                    begin
                        $error("pixel_byte: expected %02h, got %02h",
                               want.pixel_byte, got.pixel_byte);
                        mismatch_count++;
                    end
                    if (got.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((filtered_ch.valid && filtered_ch.ready)
                || (unfiltered_ch.valid && unfiltered_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles == WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned rand_base;
        int unsigned rows;
        int unsigned len;
        int unsigned pick;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: one-byte rows, None filter on the extreme byte
        queue_byte(8'(FILT_NONE), 1'b1);
        queue_byte(8'hFF, 1'b0);
        wait_idle();

        // Every filter and an unknown code, two-byte rows, one byte per pixel
        write_reg(CFG_BYTES_PER_PIXEL, 13'd1);
        write_reg(CFG_ROW_BYTES, 13'd2);
        queue_byte(8'(FILT_PAETH), 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'(FILT_UP), 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'(FILT_AVG), 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'(FILT_SUB), 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);

        // Stop mid-row, then shrink the row to zero and saturate the pixel size
        queue_byte(8'(FILT_SUB), 1'b0);
        queue_byte(8'h33, 1'b0);
        wait_idle();
        write_reg(CFG_ROW_BYTES, 13'd0);
        write_reg(CFG_BYTES_PER_PIXEL, {10'h3FF, 3'd7});
        queue_byte(8'h44, 1'b0);
        wait_idle();

        // Zero pixel size, oversized row, image start in the middle of a row
        write_reg(CFG_BYTES_PER_PIXEL, 13'd0);
        write_reg(CFG_ROW_BYTES, 13'h1FFF);
        queue_byte(8'(FILT_AVG), 1'b1);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'(FILT_SUB), 1'b1);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b0);

        // Random phases: mostly well-formed rows, some broken and cut short
        rand_base = queued_items;
        while (queued_items - rand_base < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_BYTES_PER_PIXEL,
                          {10'($urandom), ($urandom_range(0, 4) == 0)
                              ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4))});
            if ($urandom_range(0, 9) < 7)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    write_reg(CFG_ROW_BYTES, 13'd0);
                else if (pick < 4)
                    write_reg(CFG_ROW_BYTES, 13'($urandom_range(17, 64)));
                else
                    write_reg(CFG_ROW_BYTES, 13'($urandom_range(1, 16)));
            end
            rows = $urandom_range(1, 4);
            for (int r = 0; r < rows; r++)
            begin
                len = row_len();
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(0, len + 3);
                queue_row((r == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0),
                          rand_filter(), len, 1'b1);
            end
            if ($urandom_range(0, 2) == 0)
                queue_row(1'b0, rand_filter(), $urandom_range(0, row_len() - 1), 1'b1);
            // Stall the output while the sender keeps offering requests
            hold_req = 1'b1;
        end
        wait_idle();

        // Rows at the largest pixel size
        write_reg(CFG_BYTES_PER_PIXEL, 13'd4);
        write_reg(CFG_ROW_BYTES, 13'(FINAL_ROW));
        queue_row(1'b1, 8'(FILT_SUB), FINAL_ROW, 1'b0);
        queue_row(1'b0, 8'(FILT_PAETH), FINAL_ROW, 1'b0);
        wait_idle();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/unf_pkg.sv
src/unf_stream_if.sv
src/unf_ram.sv
src/unf_queue.sv
src/unf_front.sv
src/unf_back.sv
src/png_scanline_unfilter.sv
sim/tb_png_scanline_unfilter.sv
